/* design/ffpbe_pkg.sv */
// Package: constants, types and helper functions for the fill-pattern bit error counter
`default_nettype none
package ffpbe_pkg;

    localparam int POS_W       = 15;
    localparam int CNT_W       = 10;
    localparam int ERR_W       = 5;
    localparam int OFF_W       = 4;

    localparam int SCID_OFFSET_DEF = 8;

    localparam int WIN_LEN     = 14;
    localparam int WIN_STRIDE  = 4032;
    localparam int WIDE_COUNT  = 5;
    localparam int WIDE_START  = 806;
    localparam int WIDE_STOP   = 806 + 2000 * 2;
    localparam int LOCAL_START = 894;
    localparam int LOCAL_STOP  = 894 + 10296 * 2;
    localparam int POS_MAX     = 32767;
    localparam int ERR_MAX     = 1023;

    localparam logic [3:0] TYPE_NIBBLE = 4'hF;

    localparam logic [CNT_W-1:0] BITS_WIDE  = CNT_W'(700);
    localparam logic [CNT_W-1:0] BITS_LOCAL = CNT_W'(140);

    typedef logic [1:0] t_class;
    localparam t_class CLASS_NONE  = 2'd0;
    localparam t_class CLASS_WIDE  = 2'd1;
    localparam t_class CLASS_LOCAL = 2'd2;

    localparam logic REG_WIDE_CODE  = 1'b0;
    localparam logic REG_LOCAL_CODE = 1'b1;

    function automatic logic [7:0] start_fill(input logic [OFF_W-1:0] r);
        logic [7:0] v;
        case (r)
            4'd0, 4'd4, 4'd8, 4'd12: v = 8'd3;
            4'd1, 4'd5, 4'd9, 4'd13: v = 8'd255;
            default:                 v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] stop_fill(input logic [OFF_W-1:0] r);
        logic [7:0] v;
        case (r)
            4'd0, 4'd2, 4'd8, 4'd10: v = 8'd3;
            4'd1, 4'd3, 4'd9, 4'd11: v = 8'd255;
            default:                 v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] ones8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

endpackage
`default_nettype wire

/* design/ffpbe_win.sv */
// Window match and fill-mask error count for one frame byte
`default_nettype none
module ffpbe_win
    import ffpbe_pkg::*;
(
    input  wire logic [POS_W-1:0] i_pos,
    input  wire logic [7:0]       i_byte,
    input  wire t_class           i_class,
    output logic [ERR_W-1:0]      o_errs
);

    logic             s_hit, p_hit;
    logic [OFF_W-1:0] s_off, p_off;
    logic [POS_W-1:0] diff;
    logic [POS_W-1:0] base;
    logic [3:0]       s_err, p_err;

    always_comb begin
        s_hit = 1'b0;
        p_hit = 1'b0;
        s_off = '0;
        p_off = '0;
        diff  = '0;
        base  = '0;
        if (i_class == CLASS_WIDE) begin
            for (int i = 0; i < WIDE_COUNT; i++) begin
                base = POS_W'(WIDE_START + i * WIN_STRIDE);
                diff = i_pos - base;
                if (i_pos >= base && diff < POS_W'(WIN_LEN)) begin
                    s_hit = 1'b1;
                    s_off = diff[OFF_W-1:0];
                end
                base = POS_W'(WIDE_STOP + i * WIN_STRIDE);
                diff = i_pos - base;
                if (i_pos >= base && diff < POS_W'(WIN_LEN)) begin
                    p_hit = 1'b1;
                    p_off = diff[OFF_W-1:0];
                end
            end
        end else if (i_class == CLASS_LOCAL) begin
            base = POS_W'(LOCAL_START);
            diff = i_pos - base;
            if (i_pos >= base && diff < POS_W'(WIN_LEN)) begin
                s_hit = 1'b1;
                s_off = diff[OFF_W-1:0];
            end
            base = POS_W'(LOCAL_STOP);
            diff = i_pos - base;
            if (i_pos >= base && diff < POS_W'(WIN_LEN)) begin
                p_hit = 1'b1;
                p_off = diff[OFF_W-1:0];
            end
        end
    end

    assign s_err  = s_hit ? ones8(i_byte ^ start_fill(s_off)) : 4'd0;
    assign p_err  = p_hit ? ones8(i_byte ^ stop_fill(p_off)) : 4'd0;
    assign o_errs = {1'b0, s_err} + {1'b0, p_err};

endmodule
`default_nettype wire

/* design/frame_fill_pattern_bit_error_counter_unit.sv */
// Top level: fill-pattern bit error counter for telemetry minor frames
// Throughput: one frame byte per cycle unless a last byte waits on a full result register.
// When the last byte leaves the input stage, the result register loads and o_valid rises.
// Non-last bytes flow on while a result waits; only a last byte waits on a full result register.
// Reset (synchronous, active low) empties both pipeline stages, clears frame state and sets
// the type codes to wide 0, local 1.
`default_nettype none
module frame_fill_pattern_bit_error_counter_unit
    import ffpbe_pkg::*;
#(
    parameter int SCID_OFFSET = SCID_OFFSET_DEF
)(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [3:0]       i_cfg_data,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [7:0]       i_frame_byte,
    input  wire logic             i_last_byte,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [CNT_W-1:0]      o_bits_checked,
    output logic [CNT_W-1:0]      o_bit_errors,
    output logic                  o_any_error
);

    localparam logic [POS_W-1:0] TYPE_POS = POS_W'(SCID_OFFSET + 3);

    logic [3:0]       r_wide_code, r_local_code;
    logic             r_a_v, r_a_last;
    logic [7:0]       r_a_byte;
    logic [POS_W-1:0] r_pos, n_pos;
    t_class           r_class, n_class, cur_class;
    logic [CNT_W-1:0] r_err, n_err;
    logic             r_o_v;
    logic [CNT_W-1:0] r_o_bits, r_o_err;
    logic             r_o_any;

    logic             in_acc, out_acc, adv;
    logic [ERR_W-1:0] errs;
    logic [CNT_W:0]   sum;
    logic [CNT_W-1:0] tot;
    logic [CNT_W-1:0] bits;

    assign out_acc = r_o_v && !i_stall;
    assign adv     = r_a_v && (!r_a_last || !r_o_v || out_acc);
    assign o_stall = r_a_v && !adv;
    assign in_acc  = i_valid && !o_stall;

    always_comb begin
        cur_class = r_class;
        if (r_pos == TYPE_POS) begin
            if ((r_a_byte[3:0] & TYPE_NIBBLE) == r_wide_code) begin
                cur_class = CLASS_WIDE;
            end else if ((r_a_byte[3:0] & TYPE_NIBBLE) == r_local_code) begin
                cur_class = CLASS_LOCAL;
            end else begin
                cur_class = CLASS_NONE;
            end
        end
    end

    ffpbe_win u_win (
        .i_pos   (r_pos),
        .i_byte  (r_a_byte),
        .i_class (cur_class),
        .o_errs  (errs)
    );

    assign sum = {1'b0, r_err} + (CNT_W+1)'(errs);
    assign tot = (sum > (CNT_W+1)'(ERR_MAX)) ? CNT_W'(ERR_MAX) : sum[CNT_W-1:0];

    always_comb begin
        case (cur_class)
            CLASS_WIDE:  bits = BITS_WIDE;
            CLASS_LOCAL: bits = BITS_LOCAL;
            default:     bits = '0;
        endcase
    end

    always_comb begin
        n_pos   = r_pos;
        n_class = r_class;
        n_err   = r_err;
        if (adv) begin
            if (r_a_last) begin
                n_pos   = '0;
                n_class = CLASS_NONE;
                n_err   = '0;
            end else begin
                n_pos   = (r_pos < POS_W'(POS_MAX)) ? r_pos + 1'b1 : r_pos;
                n_class = cur_class;
                n_err   = tot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_code  <= 4'd0;
            r_local_code <= 4'd1;
            r_a_v        <= 1'b0;
            r_pos        <= '0;
            r_class      <= CLASS_NONE;
            r_err        <= '0;
            r_o_v        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WIDE_CODE:  r_wide_code  <= i_cfg_data;
                    REG_LOCAL_CODE: r_local_code <= i_cfg_data;
                    default:        r_wide_code  <= r_wide_code;
                endcase
            end
            if (in_acc) begin
                r_a_v <= 1'b1;
            end else if (adv) begin
                r_a_v <= 1'b0;
            end
            r_pos   <= n_pos;
            r_class <= n_class;
            r_err   <= n_err;
            if (adv && r_a_last) begin
                r_o_v <= 1'b1;
            end else if (out_acc) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_byte <= i_frame_byte;
            r_a_last <= i_last_byte;
        end
        if (adv && r_a_last) begin
            r_o_bits <= bits;
            r_o_err  <= tot;
            r_o_any  <= (tot != '0);
        end
    end

    assign o_valid        = r_o_v;
    assign o_bits_checked = r_o_bits;
    assign o_bit_errors   = r_o_err;
    assign o_any_error    = r_o_any;

endmodule
`default_nettype wire
